// ===== rtl/triangle_scanline_fill_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TRIANGLE_SCANLINE_FILL_MACROS_SVH
`define TRIANGLE_SCANLINE_FILL_MACROS_SVH
// Assert that an implication holds at every clock edge outside reset.
`define TSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that an implication holds in the cycle after the antecedent.
`define TSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/tsf_pkg.sv =====
// Package with types and constants of the triangle scanline fill block.
package tsf_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_SPANS = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_DIV,
        ST_UPPER,
        ST_LOWER_INIT,
        ST_LOWER,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SLOPE_SHORT,
        SLOPE_LONG,
        SLOPE_LOW
    } t_slope_sel;

    typedef struct packed {
        logic       load;
        logic       sort_step;
        logic       div_start;
        t_slope_sel div_sel;
        logic       upper_init;
        logic       lower_init;
        logic       emit;
        logic       advance_upper;
        logic       advance_lower;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic       upper_end;
        logic       lower_end;
        logic       span_full;
        logic       out_free;
    } t_status;
endpackage

// ===== rtl/tsf_if.sv =====
// Valid/ready stream interfaces for triangles and spans.
interface tsf_tri_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_x;
    logic [5:0] first_y;
    logic [7:0] second_x;
    logic [5:0] second_y;
    logic [7:0] third_x;
    logic [5:0] third_y;
    logic [7:0] fill_level;
    modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                    fill_level, input ready);
    modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                  fill_level, output ready);
endinterface

interface tsf_span_if;
    logic       valid;
    logic       ready;
    logic [5:0] span_row;
    logic [7:0] span_left;
    logic [7:0] span_right;
    logic [7:0] span_level;
    logic       span_last;
    modport source (output valid, span_row, span_left, span_right, span_level, span_last,
                    input ready);
    modport sink (input valid, span_row, span_left, span_right, span_level, span_last,
                  output ready);
endinterface

// ===== rtl/tsf_div.sv =====
// Restoring serial divider for the edge slope magnitudes, one quotient bit per cycle.
module tsf_div #(
    parameter int FRAC_BITS = tsf_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [7:0]             i_dividend,
    input  logic [5:0]             i_divisor,
    output logic [FRAC_BITS+7:0]   o_quotient,
    output logic                   o_done
);
    localparam int QW = FRAC_BITS + 8;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] r_num;
    logic [QW-1:0] r_quo;
    logic [6:0]    r_rem;
    logic [5:0]    r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [6:0]    w_trial;
    logic          w_ge;

    assign w_trial = {r_rem[5:0], r_num[QW-1]};
    assign w_ge = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_dividend, {FRAC_BITS{1'b0}}};
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[QW-2:0], 1'b0};
            r_rem <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done = !r_busy && !i_start;
endmodule

// ===== rtl/tsf_ctrl.sv =====
// Controller state machine that sequences sort, slope division and span walking.
module tsf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tsf_pkg::t_status i_status,
    output tsf_pkg::t_cmd   o_cmd
);
    tsf_pkg::t_state     r_state, n_state;
    tsf_pkg::t_slope_sel r_sel, n_sel;
    logic [1:0]          r_step, n_step;
    logic                r_started, n_started;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tsf_pkg::ST_IDLE;
            r_sel     <= tsf_pkg::SLOPE_SHORT;
            r_step    <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_step    <= n_step;
            r_started <= n_started;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_step    = r_step;
        n_started = r_started;
        o_cmd     = '0;
        o_cmd.div_sel = r_sel;
        o_in_ready = 1'b0;
        case (r_state)
            tsf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step  = '0;
                    n_state = tsf_pkg::ST_SORT;
                end
            end
            tsf_pkg::ST_SORT: begin
                o_cmd.sort_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == 2'd2) begin
                    n_sel     = tsf_pkg::SLOPE_SHORT;
                    n_started = 1'b0;
                    n_state   = tsf_pkg::ST_DIV;
                end
            end
            tsf_pkg::ST_DIV: begin
                if (!r_started) begin
                    o_cmd.div_start = 1'b1;
                    n_started = 1'b1;
                end else if (i_status.div_done) begin
                    n_started = 1'b0;
                    case (r_sel)
                        tsf_pkg::SLOPE_SHORT: n_sel = tsf_pkg::SLOPE_LONG;
                        tsf_pkg::SLOPE_LONG:  n_sel = tsf_pkg::SLOPE_LOW;
                        default: begin
                            o_cmd.upper_init = 1'b1;
                            n_state = tsf_pkg::ST_UPPER;
                        end
                    endcase
                end
            end
            tsf_pkg::ST_UPPER: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.advance_upper = 1'b1;
                    if (i_status.span_full) begin
                        o_cmd.last = 1'b1;
                        n_state = tsf_pkg::ST_IDLE;
                    end else if (i_status.upper_end) begin
                        n_state = tsf_pkg::ST_LOWER_INIT;
                    end
                end
            end
            tsf_pkg::ST_LOWER_INIT: begin
                o_cmd.lower_init = 1'b1;
                n_state = tsf_pkg::ST_LOWER;
            end
            tsf_pkg::ST_LOWER: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.advance_lower = 1'b1;
                    if (i_status.span_full || i_status.lower_end) begin
                        o_cmd.last = 1'b1;
                        n_state = tsf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tsf_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/tsf_datapath.sv =====
// Datapath with vertex sort, slope registers, edge accumulators and span output register.
module tsf_datapath #(
    parameter int FRAC_BITS = tsf_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsf_pkg::t_cmd     i_cmd,
    output tsf_pkg::t_status  o_status,
    tsf_tri_if.sink           tri_in,
    tsf_span_if.source        span_out
);
    localparam int QW = FRAC_BITS + 8;
    localparam int AW = FRAC_BITS + 16;

    logic [7:0]          r_vx [3];
    logic [5:0]          r_vy [3];
    logic [7:0]          r_level;
    logic signed [QW:0]  r_slope [3];
    logic signed [AW-1:0] r_acc1, r_acc2;
    logic [5:0]          r_row;
    logic [6:0]          r_count;
    logic [1:0]          r_sort_idx;
    logic                r_valid;
    logic [5:0]          r_o_row;
    logic [7:0]          r_o_left, r_o_right;
    logic [7:0]          r_o_level;
    logic                r_o_last;

    logic [7:0]          w_dx_mag;
    logic                w_dx_neg;
    logic [5:0]          w_dy;
    logic [QW-1:0]       w_quo;
    logic                w_div_done;
    logic [1:0]          w_a, w_b, w_ia, w_ib;
    logic [7:0]          w_l, w_r;
    logic [AW-1:0]       w_long_start;

    always_comb begin
        w_ia = 2'd0;
        w_ib = 2'd1;
        case (i_cmd.div_sel)
            tsf_pkg::SLOPE_SHORT: begin w_ia = 2'd0; w_ib = 2'd1; end
            tsf_pkg::SLOPE_LONG:  begin w_ia = 2'd0; w_ib = 2'd2; end
            tsf_pkg::SLOPE_LOW:   begin w_ia = 2'd1; w_ib = 2'd2; end
            default:              begin w_ia = 2'd0; w_ib = 2'd1; end
        endcase
        w_dx_neg = r_vx[w_ib] < r_vx[w_ia];
        w_dx_mag = w_dx_neg ? (r_vx[w_ia] - r_vx[w_ib]) : (r_vx[w_ib] - r_vx[w_ia]);
        w_dy = r_vy[w_ib] - r_vy[w_ia];
    end

    tsf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dx_mag),
        .i_divisor  (w_dy),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    assign w_a = (r_sort_idx == 2'd1) ? 2'd1 : 2'd0;
    assign w_b = (r_sort_idx == 2'd1) ? 2'd2 : 2'd1;

    function automatic logic [7:0] to_pix(input logic signed [AW-1:0] acc);
        logic [AW-FRAC_BITS-1:0] v;
        v = acc[AW-1:FRAC_BITS];
        if (acc[AW-1]) begin
            return 8'd0;
        end
        if (v > (AW-FRAC_BITS)'(255)) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    assign w_l = to_pix(r_acc1);
    assign w_r = to_pix(r_acc2);
    assign w_long_start = {{(AW-FRAC_BITS-8){1'b0}}, r_vx[0], {FRAC_BITS{1'b0}}}
                        + AW'(r_slope[1]) * AW'(r_vy[1] - r_vy[0]);

    always_ff @(posedge i_clk) begin
        if (tri_in.valid && tri_in.ready) begin
            r_vx[0] <= tri_in.first_x;  r_vy[0] <= tri_in.first_y;
            r_vx[1] <= tri_in.second_x; r_vy[1] <= tri_in.second_y;
            r_vx[2] <= tri_in.third_x;  r_vy[2] <= tri_in.third_y;
            r_level <= tri_in.fill_level;
            r_sort_idx <= '0;
        end else if (i_cmd.sort_step) begin
            r_sort_idx <= r_sort_idx + 1'b1;
            if (r_vy[w_a] > r_vy[w_b]) begin
                r_vy[w_a] <= r_vy[w_b]; r_vy[w_b] <= r_vy[w_a];
                r_vx[w_a] <= r_vx[w_b]; r_vx[w_b] <= r_vx[w_a];
            end
        end
        if (w_div_done && !i_cmd.div_start && (i_cmd.div_sel != tsf_pkg::SLOPE_LOW
                || !i_cmd.upper_init)) begin
            r_slope[i_cmd.div_sel] <= (w_dy == '0) ? '0 :
                (w_dx_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo}));
        end
        if (i_cmd.upper_init) begin
            r_acc1 <= AW'({r_vx[0], {FRAC_BITS{1'b0}}});
            r_acc2 <= AW'({r_vx[0], {FRAC_BITS{1'b0}}});
            r_row  <= r_vy[0];
        end else if (i_cmd.lower_init) begin
            r_acc1 <= AW'({r_vx[1], {FRAC_BITS{1'b0}}});
            r_acc2 <= w_long_start;
            r_row  <= r_vy[1];
        end else if (i_cmd.advance_upper) begin
            r_acc1 <= r_acc1 + AW'(r_slope[0]);
            r_acc2 <= r_acc2 + AW'(r_slope[1]);
            r_row  <= r_row + 1'b1;
        end else if (i_cmd.advance_lower) begin
            r_acc1 <= r_acc1 + AW'(r_slope[2]);
            r_acc2 <= r_acc2 + AW'(r_slope[1]);
            r_row  <= r_row + 1'b1;
        end
        if (i_cmd.emit) begin
            r_o_row   <= r_row;
            r_o_left  <= (w_l > w_r) ? w_r : w_l;
            r_o_right <= (w_l > w_r) ? w_l : w_r;
            r_o_level <= r_level;
            r_o_last  <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_cmd.load) begin
                r_count <= '0;
            end else if (i_cmd.emit) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (span_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_status.div_done  = w_div_done;
    assign o_status.upper_end = (r_row == r_vy[1]);
    assign o_status.lower_end = (r_row == r_vy[2]);
    assign o_status.span_full = (r_count == 7'(tsf_pkg::MAX_SPANS - 1));
    assign o_status.out_free  = !r_valid || span_out.ready;

    assign span_out.valid      = r_valid;
    assign span_out.span_row   = r_o_row;
    assign span_out.span_left  = r_o_left;
    assign span_out.span_right = r_o_right;
    assign span_out.span_level = r_o_level;
    assign span_out.span_last  = r_o_last;
endmodule

// ===== rtl/triangle_scanline_fill.sv =====
// Sequence: a vertex sort by y, then three serial slope divisions one after another,
// then one span per cycle while the output is taken.
// The serial divider and the one span walker set the pace; one triangle is in work at a time.
// The lower half has an extra setup state, ST_LOWER_INIT, for the long edge restart.
// A new triangle is accepted once the last span is in the output register.
// Reset is synchronous and active low; it clears the controller and the output valid.
module triangle_scanline_fill #(
    parameter int FRAC_BITS = tsf_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsf_tri_if.sink     tri_in,
    tsf_span_if.source  span_out
);
    tsf_pkg::t_cmd    w_cmd;
    tsf_pkg::t_status w_status;

    tsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (tri_in.valid),
        .o_in_ready (tri_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tsf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .tri_in   (tri_in),
        .span_out (span_out)
    );
endmodule

// ===== rtl/tsf_checker.sv =====
// Port checker for the triangle scanline fill block and its bind.
`include "triangle_scanline_fill_macros.svh"
module tsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_left,
    input logic [7:0] out_right,
    input logic [5:0] out_row
);
    `TSF_ASSERT_IMP(a_order, i_clk, i_rst_n, out_valid, out_left <= out_right)
    `TSF_ASSERT_NEXT(a_busy, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    `TSF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_row))
endmodule

bind triangle_scanline_fill tsf_checker u_tsf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (tri_in.valid),
    .in_ready  (tri_in.ready),
    .out_valid (span_out.valid),
    .out_ready (span_out.ready),
    .out_left  (span_out.span_left),
    .out_right (span_out.span_right),
    .out_row   (span_out.span_row)
);
